>>> src/ising_pkg.sv
// ============================================================================
// ising_pkg
// Shared types and constants for the Ising Metropolis site update block.
// ============================================================================
package ising_pkg;

    // Built lattice side; the spin store holds SIDE rows of SIDE spins.
    localparam int SIDE_DEFAULT = 64;

    // Fixed field widths.
    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int FRAC_W  = 32;
    localparam int DE_W    = 5;
    localparam int SIDE_W  = 7;
    localparam int COUP_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_FLIP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Coupling modes; any other code acts as zero coupling.
    localparam logic [COUP_W-1:0] COUP_POS  = 2'd0;
    localparam logic [COUP_W-1:0] COUP_NEG  = 2'd1;
    localparam logic [COUP_W-1:0] COUP_ZERO = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_SM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_LG = 2'd3;

    // Reset value of the side register.
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd32;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NBR_UP,
        ST_NBR_DN,
        ST_WB
    } ctrl_state_t;

    // Which row the memory read port addresses.
    typedef enum logic [1:0] {
        ROW_IN,
        ROW_UP,
        ROW_DN
    } row_sel_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        row_sel_t rd_sel;
        logic     cap_center;
        logic     cap_up;
        logic     wb;
        logic     clr_wr;
    } ising_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic stall;
        logic clr_last;
    } ising_stat_t;

endpackage

>>> src/ising_ctrl.sv
// ============================================================================
// ising_ctrl
// Sequencer for the clearing pass and the site update.
// ============================================================================
module ising_ctrl
    import ising_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ising_stat_t stat,
    output ising_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_NBR_UP;
            end
            ST_NBR_UP: state_next = ST_NBR_DN;
            ST_NBR_DN: state_next = ST_WB;
            ST_WB: begin
                if (!stat.stall) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        cmd.rd_sel = ROW_IN;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
                cmd.rd_en     = s_tvalid;
                cmd.rd_sel    = ROW_IN;
            end
            ST_NBR_UP: begin
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = ROW_UP;
                cmd.cap_center = 1'b1;
            end
            ST_NBR_DN: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ROW_DN;
                cmd.cap_up = 1'b1;
            end
            ST_WB: begin
                cmd.wb = !stat.stall;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/ising_dp.sv
// ============================================================================
// ising_dp
// Datapath: configuration registers, row-wide spin memory, neighbor capture,
// energy change, acceptance and the output register.
// ============================================================================
module ising_dp
    import ising_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes.
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input item fields.
    input  logic [CMD_W-1:0]      in_command,
    input  logic [COORD_W-1:0]    in_site_x,
    input  logic [COORD_W-1:0]    in_site_y,
    input  logic [FRAC_W-1:0]     in_random_fraction,
    input  logic                  in_write_spin,
    // Result item.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_spin,
    output logic                  out_flipped,
    output logic signed [DE_W-1:0] out_energy_change,
    output logic                  out_site_error,
    // Control.
    input  ising_cmd_t            cmd,
    output ising_stat_t           stat
);

    localparam int AW = $clog2(SIDE);
    localparam int LW = $clog2(SIDE + 1);
    localparam int CW = (LW > SIDE_W) ? LW : SIDE_W;

    // Configuration registers.
    logic [SIDE_W-1:0] side_reg;
    logic [COUP_W-1:0] coup_reg;
    logic [FRAC_W-1:0] acc_sm_reg;
    logic [FRAC_W-1:0] acc_lg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg   <= SIDE_RESET;
            coup_reg   <= COUP_POS;
            acc_sm_reg <= '0;
            acc_lg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SIDE:   side_reg   <= cfg_data[SIDE_W-1:0];
                REG_COUP:   coup_reg   <= cfg_data[COUP_W-1:0];
                REG_ACC_SM: acc_sm_reg <= cfg_data[FRAC_W-1:0];
                REG_ACC_LG: acc_lg_reg <= cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched item.
    logic [CMD_W-1:0]   cmd_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [FRAC_W-1:0]  rnd_reg;
    logic               wspin_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg   <= in_command;
            x_reg     <= in_site_x;
            y_reg     <= in_site_y;
            rnd_reg   <= in_random_fraction;
            wspin_reg <= in_write_spin;
        end
    end

    // Effective side, range check and wrapped neighbor coordinates.
    logic [CW-1:0] side_ext, side_eff, x_ext, y_ext;
    logic [CW-1:0] xp, xm, yp, ym;
    logic          site_err;

    always_comb begin
        side_ext = CW'(side_reg);
        if (side_ext < CW'(2)) begin
            side_eff = CW'(2);
        end else if (side_ext > CW'(SIDE)) begin
            side_eff = CW'(SIDE);
        end else begin
            side_eff = side_ext;
        end
        x_ext    = CW'(x_reg);
        y_ext    = CW'(y_reg);
        site_err = (x_ext >= side_eff) || (y_ext >= side_eff);
        xp = (CW'(x_ext + CW'(1)) == side_eff) ? '0 : CW'(x_ext + CW'(1));
        yp = (CW'(y_ext + CW'(1)) == side_eff) ? '0 : CW'(y_ext + CW'(1));
        xm = (x_ext == '0) ? CW'(side_eff - CW'(1)) : CW'(x_ext - CW'(1));
        ym = (y_ext == '0) ? CW'(side_eff - CW'(1)) : CW'(y_ext - CW'(1));
    end

    logic [AW-1:0] xi, xpi, xmi, yi, ypi, ymi;
    assign xi  = AW'(x_ext);
    assign xpi = AW'(xp);
    assign xmi = AW'(xm);
    assign yi  = AW'(y_ext);
    assign ypi = AW'(yp);
    assign ymi = AW'(ym);

    // Clearing pass counter, one row per cycle after reset.
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    assign stat.clr_last = (clr_cnt_reg == AW'(SIDE - 1));
    assign clr_cnt_next  = stat.clr_last ? clr_cnt_reg : AW'(clr_cnt_reg + AW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Spin memory: one row of SIDE spins per word.
    logic [SIDE-1:0] spin_mem [SIDE];
    logic [SIDE-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [SIDE-1:0] wr_data;
    logic            wr_en;
    logic [SIDE-1:0] new_row;
    logic            mem_wr_item;

    always_comb begin
        case (cmd.rd_sel)
            ROW_IN:  rd_addr = AW'(in_site_y);
            ROW_UP:  rd_addr = ymi;
            ROW_DN:  rd_addr = ypi;
            default: rd_addr = yi;
        endcase
    end

    assign mem_wr_item = cmd.wb && !site_err;
    assign wr_en   = cmd.clr_wr || mem_wr_item;
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : yi;
    assign wr_data = cmd.clr_wr ? '1 : new_row;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            spin_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= spin_mem[rd_addr];
        end
    end

    // Captured center row and upper neighbor.
    logic [SIDE-1:0] center_reg;
    logic            up_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_center) begin
            center_reg <= rd_data_reg;
        end
        if (cmd.cap_up) begin
            up_reg <= rd_data_reg[xi];
        end
    end

    // Energy change and acceptance; the lower neighbor comes straight from
    // the read register, which holds while the write-back waits.
    logic                   old_spin, new_spin, accept;
    logic [2:0]             ones;
    logic signed [DE_W:0]   e_wide;
    logic signed [DE_W-1:0] e_site, de;

    always_comb begin
        old_spin = center_reg[xi];
        ones     = 3'(center_reg[xmi]) + 3'(center_reg[xpi]) + 3'(up_reg)
                 + 3'(rd_data_reg[xi]);
        // 2*s*nbr with nbr = 2*ones - 4, for an up spin.
        e_wide   = $signed({1'b0, ones, 2'b00}) - (DE_W + 1)'(8);
        e_site   = DE_W'(e_wide);
        if (!old_spin) e_site = -e_site;
        case (coup_reg)
            COUP_POS: de = e_site;
            COUP_NEG: de = -e_site;
            COUP_ZERO: de = '0;
            default:  de = '0;
        endcase
        if (de <= 0) begin
            accept = 1'b1;
        end else if (de == DE_W'(4)) begin
            accept = rnd_reg < acc_sm_reg;
        end else begin
            accept = rnd_reg < acc_lg_reg;
        end
        case (cmd_reg)
            CMD_FLIP:  new_spin = old_spin ^ accept;
            CMD_WRITE: new_spin = wspin_reg;
            default:   new_spin = old_spin;
        endcase
        new_row     = center_reg;
        new_row[xi] = new_spin;
    end

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic                   spin_reg, flipped_reg, err_reg;
    logic signed [DE_W-1:0] de_reg;

    assign stat.stall = out_valid_reg && !out_ready;

    always_comb begin
        if (cmd.wb) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            err_reg     <= site_err;
            spin_reg    <= site_err ? 1'b0 : new_spin;
            flipped_reg <= site_err ? 1'b0 : (new_spin != old_spin);
            de_reg      <= (site_err || (cmd_reg != CMD_FLIP)) ? '0 : de;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_spin          = spin_reg;
    assign out_flipped       = flipped_reg;
    assign out_energy_change = de_reg;
    assign out_site_error    = err_reg;

endmodule

>>> src/ising_metropolis_site_update_top.sv
// ============================================================================
// ising_metropolis_site_update_top
// Single-site Metropolis update on a periodic square lattice of spins.
// ============================================================================
// Usage:
// Items arrive on the s_ channel: s_tuser carries the command (attempt,
// write, read), s_tdata the site coordinates, random fraction and write
// spin. Each item yields exactly one result on the m_ channel: spin,
// flipped and energy change in m_tdata, the site error flag in m_tuser.
// Registers are to be written by the user through the cfg_ channel only while
// no item is in flight; the block does not enforce this. An item occupies the
// block from the accepting cycle through the NBR_UP, NBR_DN and WB states:
// the accepting cycle, NBR_UP and NBR_DN read the site row and the rows above
// and below through the single read port, and WB writes the updated row back
// and loads the output register, which drives m_tvalid.
// The next item is accepted as soon as the result is loaded, even while
// the receiver still holds off; if the output register is full when a new
// result is due, the write-back cycle waits until m_tready.
// After reset the block sets every row of the store to spin-up in a clearing
// pass; s_tready stays low during that pass, configuration writes are taken
// throughout.
// ============================================================================
module ising_metropolis_site_update_top
    import ising_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] site_x, [11:6] site_y, [43:12] random_fraction, [44] write_spin
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      s_tuser,
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] spin, [1] flipped, [6:2] energy_change
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] site_error
    output logic                  m_tuser
);

    ising_cmd_t  cmd;
    ising_stat_t stat;

    logic                   out_spin, out_flipped, out_site_error;
    logic signed [DE_W-1:0] out_energy_change;

    assign cfg_ready = 1'b1;

    ising_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ising_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_command         (s_tuser),
        .in_site_x          (s_tdata[5:0]),
        .in_site_y          (s_tdata[11:6]),
        .in_random_fraction (s_tdata[43:12]),
        .in_write_spin      (s_tdata[44]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_spin           (out_spin),
        .out_flipped        (out_flipped),
        .out_energy_change  (out_energy_change),
        .out_site_error     (out_site_error),
        .cmd                (cmd),
        .stat               (stat)
    );

    assign m_tdata = {1'b0, out_energy_change, out_flipped, out_spin};
    assign m_tuser = out_site_error;

    // An accepted item keeps the input side closed on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Reset always leads into the clearing pass with the input closed.
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // A result with a site error carries no spin, flip or energy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("site error result with nonzero payload");

    // A result that kept its spin never reports an energy drop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser && !m_tdata[1]) |-> !m_tdata[6])
        else $error("energy drop reported without a flip");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives site commands into the Ising Metropolis update block, keeps its own
// copy of the spin lattice and registers, and checks every result item.
// A directed table covers reset state, range errors, wrap-around, threshold
// edges and every coupling code. Randomized phases at several lattice sides
// and thresholds follow, with gaps and stalls on both streams.
// ============================================================================
module testbench;
    import ising_pkg::*;

    localparam int          N_DIR       = 32;
    localparam int          N_PHASES    = 10;
    localparam int          PHASE_ITEMS = 170;
    localparam int unsigned CYCLE_LIMIT = 600000;

    // Codes the package leaves unnamed: command three reads, coupling three is zero.
    localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
    localparam logic [COUP_W-1:0] COUP_SPARE = 2'd3;

    // Side register per random phase, phase 0 in the lowest bits.
    localparam logic [7*N_PHASES-1:0] PHASE_SIDES = {
        7'd63, 7'd33, 7'd17, 7'd5, 7'd127, 7'd64, 7'd3, 7'd1, 7'd0, 7'd2
    };

    typedef struct packed {
        logic            spin;
        logic            flipped;
        logic [DE_W-1:0] energy;
        logic            err;
    } site_result_t;

    localparam site_result_t NONE_KNOWN = '0;

    // Directed rows: predicted item, item with result typed in, register write.
    typedef enum logic [1:0] {DIR_SITE, DIR_KNOWN, DIR_REG} dir_kind_t;

    typedef struct packed {
        dir_kind_t            kind;
        logic [CMD_W-1:0]     cmd;    // register index for register rows
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [FRAC_W-1:0]    word;   // random fraction, or register data
        logic                 wspin;
        site_result_t         known;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    // Lattice and register copies used for prediction.
    logic              lattice [SIDE_DEFAULT*SIDE_DEFAULT];
    logic [SIDE_W-1:0] side_reg;
    logic [COUP_W-1:0] coup_reg;
    logic [FRAC_W-1:0] thr_small;
    logic [FRAC_W-1:0] thr_large;

    site_result_t site_results_due [$];
    dir_row_t     dir_table [N_DIR];

    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;
    int unsigned result_count = 0;
    int unsigned rcv_hold    = 0;
    logic        snd_busy    = 1'b1;
    logic        rcv_busy    = 1'b1;

    ising_metropolis_site_update_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pause_len();
        if ($urandom_range(0, 4) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned side_span();
        if (side_reg < 2) return 2;
        if (side_reg > SIDE_DEFAULT) return SIDE_DEFAULT;
        return side_reg;
    endfunction

    function automatic int spin_sign(int unsigned cx, int unsigned cy);
        return lattice[cx + cy * SIDE_DEFAULT] ? 1 : -1;
    endfunction

    // Applies one command to the lattice copy and returns the result item.
    function automatic site_result_t update_site(logic [CMD_W-1:0] cmd,
                                                 logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y,
                                                 logic [FRAC_W-1:0] frac,
                                                 logic wspin);
        site_result_t res;
        int unsigned  span;
        int unsigned  pos;
        int           own;
        int           nbr;
        int           de;
        logic         was;
        logic         now;
        res  = '0;
        span = side_span();
        if (x >= span || y >= span) begin
            res.err = 1'b1;
            return res;
        end
        pos = x + y * SIDE_DEFAULT;
        was = lattice[pos];
        now = was;
        de  = 0;
        if (cmd == CMD_FLIP) begin
            own = was ? 1 : -1;
            nbr = spin_sign((x + 1) % span, y) + spin_sign((x + span - 1) % span, y)
                + spin_sign(x, (y + 1) % span) + spin_sign(x, (y + span - 1) % span);
            case (coup_reg)
                COUP_POS: de = 2 * own * nbr;
                COUP_NEG: de = -2 * own * nbr;
                default:  de = 0;
            endcase
            // A rise is taken only when the fraction lies below its threshold.
            if (de <= 0 || (de == 4 && frac < thr_small) || (de == 8 && frac < thr_large))
                now = ~was;
        end else if (cmd == CMD_WRITE) begin
            now = wspin;
        end
        lattice[pos] = now;
        res.spin    = now;
        res.flipped = (now != was);
        res.energy  = de[DE_W-1:0];
        return res;
    endfunction

    task automatic flag_error(input string text);
        fail_count++;
        if (fail_count <= 10) $display("%s", text);
    endtask

    // Offers one item, and predicts its result once it is taken.
    task automatic send_site(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [FRAC_W-1:0] frac,
                             input logic wspin, input bit use_known,
                             input site_result_t known);
        int unsigned  gap;
        site_result_t pred;
        gap = (snd_busy && $urandom_range(0, 1) == 1) ? pause_len() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'd0, wspin, frac, y, x};
        do @(posedge aclk); while (!s_tready);
        pred = update_site(cmd, x, y, frac, wspin);
        site_results_due.push_back(use_known ? known : pred);
    endtask

    // Drops the input stream and waits until every result is back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (site_results_due.size() != 0) @(posedge aclk);
    endtask

    // cfg_valid stays high for back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SIDE:   side_reg  = data[SIDE_W-1:0];
            REG_COUP:   coup_reg  = data[COUP_W-1:0];
            REG_ACC_SM: thr_small = data;
            default:    thr_large = data;
        endcase
    endtask

    // Cycle count, busy/calm stretches on both streams, and the timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) begin
            snd_busy <= ($urandom_range(0, 3) != 0);
            rcv_busy <= ($urandom_range(0, 3) != 0);
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: check each item taken, then choose the next ready level.
    always @(posedge aclk) begin
        site_result_t got;
        site_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.spin    = m_tdata[0];
            got.flipped = m_tdata[1];
            got.energy  = m_tdata[6:2];
            got.err     = m_tuser;
            if (site_results_due.size() == 0) begin
                flag_error($sformatf("result %0d arrived with none expected", result_count));
            end else begin
                want = site_results_due.pop_front();
                if (got !== want)
                    flag_error($sformatf({"result %0d: expected spin %0b flipped %0b dE %0d ",
                        "err %0b, got spin %0b flipped %0b dE %0d err %0b"}, result_count,
                        want.spin, want.flipped, $signed(want.energy), want.err,
                        got.spin, got.flipped, $signed(got.energy), got.err));
            end
            result_count++;
        end
        if (rcv_hold != 0) begin
            m_tready <= 1'b0;
            rcv_hold--;
        end else if (rcv_busy && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rcv_hold = pause_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        dir_row_t          row;
        int unsigned       span;
        int unsigned       pick;
        logic [CMD_W-1:0]  cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FRAC_W-1:0] frac;
        logic [COUP_W-1:0] coup;

        // Reset contents: every spin up, side 32, positive coupling, thresholds zero.
        dir_table[0]  = '{DIR_KNOWN, CMD_READ, 6'd0, 6'd0, 32'h0, 1'b0, '{1'b1, 1'b0, 5'd0, 1'b0}};
        dir_table[1]  = '{DIR_KNOWN, CMD_READ, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1,
                          '{1'b0, 1'b0, 5'd0, 1'b1}};
        dir_table[2]  = '{DIR_KNOWN, CMD_FLIP, 6'd32, 6'd0, 32'hFFFF_FFFF, 1'b0,
                          '{1'b0, 1'b0, 5'd0, 1'b1}};
        dir_table[3]  = '{DIR_KNOWN, CMD_WRITE, 6'd0, 6'd32, 32'h0, 1'b1,
                          '{1'b0, 1'b0, 5'd0, 1'b1}};
        // All neighbors up: a rise of 8 with a zero threshold never flips.
        dir_table[4]  = '{DIR_KNOWN, CMD_FLIP, 6'd5, 6'd5, 32'h0, 1'b0, '{1'b1, 1'b0, 5'd8, 1'b0}};
        dir_table[5]  = '{DIR_KNOWN, CMD_WRITE, 6'd31, 6'd31, 32'h0, 1'b0,
                          '{1'b0, 1'b1, 5'd0, 1'b0}};
        dir_table[6]  = '{DIR_KNOWN, CMD_WRITE, 6'd31, 6'd31, 32'h0, 1'b0,
                          '{1'b0, 1'b0, 5'd0, 1'b0}};
        // Corner site with wrapped neighbors, all up: a drop of 8 always flips.
        dir_table[7]  = '{DIR_KNOWN, CMD_FLIP, 6'd31, 6'd31, 32'hFFFF_FFFF, 1'b0,
                          '{1'b1, 1'b1, -5'sd8, 1'b0}};
        dir_table[8]  = '{DIR_KNOWN, CMD_WRITE, 6'd0, 6'd0, 32'h0, 1'b0, '{1'b0, 1'b1, 5'd0, 1'b0}};
        dir_table[9]  = '{DIR_SITE, CMD_FLIP, 6'd31, 6'd0, 32'h0, 1'b0, NONE_KNOWN};
        // Threshold edges for a rise of 4.
        dir_table[10] = '{DIR_REG, REG_ACC_SM, 6'd0, 6'd0, 32'h8000_0000, 1'b0, NONE_KNOWN};
        dir_table[11] = '{DIR_SITE, CMD_FLIP, 6'd31, 6'd0, 32'h8000_0000, 1'b0, NONE_KNOWN};
        dir_table[12] = '{DIR_SITE, CMD_FLIP, 6'd31, 6'd0, 32'h7FFF_FFFF, 1'b0, NONE_KNOWN};
        dir_table[13] = '{DIR_SITE, CMD_SPARE, 6'd31, 6'd0, 32'h0, 1'b1, NONE_KNOWN};
        // Threshold edges for a rise of 8, at the top of the range.
        dir_table[14] = '{DIR_REG, REG_ACC_LG, 6'd0, 6'd0, 32'hFFFF_FFFF, 1'b0, NONE_KNOWN};
        dir_table[15] = '{DIR_SITE, CMD_FLIP, 6'd10, 6'd10, 32'hFFFF_FFFF, 1'b0, NONE_KNOWN};
        dir_table[16] = '{DIR_SITE, CMD_FLIP, 6'd10, 6'd10, 32'hFFFF_FFFE, 1'b0, NONE_KNOWN};
        // Every coupling code.
        dir_table[17] = '{DIR_REG, REG_COUP, 6'd0, 6'd0, {30'd0, COUP_NEG}, 1'b0, NONE_KNOWN};
        dir_table[18] = '{DIR_SITE, CMD_FLIP, 6'd10, 6'd10, 32'h0, 1'b0, NONE_KNOWN};
        dir_table[19] = '{DIR_REG, REG_COUP, 6'd0, 6'd0, {30'd0, COUP_SPARE}, 1'b0, NONE_KNOWN};
        dir_table[20] = '{DIR_SITE, CMD_FLIP, 6'd20, 6'd20, 32'hFFFF_FFFF, 1'b0, NONE_KNOWN};
        dir_table[21] = '{DIR_REG, REG_COUP, 6'd0, 6'd0, {30'd0, COUP_ZERO}, 1'b0, NONE_KNOWN};
        dir_table[22] = '{DIR_SITE, CMD_FLIP, 6'd20, 6'd20, 32'hFFFF_FFFF, 1'b0, NONE_KNOWN};
        // Side below two clamps to a 2x2 lattice, where both neighbors coincide.
        dir_table[23] = '{DIR_REG, REG_COUP, 6'd0, 6'd0, {30'd0, COUP_POS}, 1'b0, NONE_KNOWN};
        dir_table[24] = '{DIR_REG, REG_SIDE, 6'd0, 6'd0, 32'd0, 1'b0, NONE_KNOWN};
        dir_table[25] = '{DIR_KNOWN, CMD_READ, 6'd2, 6'd0, 32'h0, 1'b0, '{1'b0, 1'b0, 5'd0, 1'b1}};
        dir_table[26] = '{DIR_SITE, CMD_FLIP, 6'd1, 6'd1, 32'h0, 1'b0, NONE_KNOWN};
        dir_table[27] = '{DIR_SITE, CMD_FLIP, 6'd0, 6'd0, 32'h0, 1'b0, NONE_KNOWN};
        // Side above the built size clamps to 64; spins keep their places.
        dir_table[28] = '{DIR_REG, REG_SIDE, 6'd0, 6'd0, 32'd127, 1'b0, NONE_KNOWN};
        dir_table[29] = '{DIR_SITE, CMD_FLIP, 6'd63, 6'd63, 32'h0, 1'b0, NONE_KNOWN};
        dir_table[30] = '{DIR_KNOWN, CMD_WRITE, 6'd63, 6'd0, 32'h0, 1'b1,
                          '{1'b1, 1'b0, 5'd0, 1'b0}};
        dir_table[31] = '{DIR_SITE, CMD_READ, 6'd63, 6'd63, 32'h0, 1'b0, NONE_KNOWN};

        foreach (lattice[i]) lattice[i] = 1'b1;
        side_reg  = SIDE_RESET;
        coup_reg  = COUP_POS;
        thr_small = '0;
        thr_large = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        for (int i = 0; i < N_DIR; i++) begin
            row = dir_table[i];
            if (row.kind == DIR_REG) begin
                wait_idle();
                write_reg(row.cmd, row.word);
                if (i + 1 == N_DIR || dir_table[i + 1].kind != DIR_REG) cfg_valid <= 1'b0;
            end else begin
                send_site(row.cmd, row.x, row.y, row.word, row.wspin,
                          row.kind == DIR_KNOWN, row.known);
            end
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0:       coup = COUP_POS;
                1:       coup = COUP_NEG;
                2:       coup = COUP_ZERO;
                default: coup = COUP_SPARE;
            endcase
            write_reg(REG_SIDE, {25'd0, PHASE_SIDES[p*7 +: 7]});
            write_reg(REG_COUP, {30'd0, coup});
            case (p % 3)
                0: begin
                    write_reg(REG_ACC_SM, $urandom);
                    write_reg(REG_ACC_LG, $urandom);
                end
                1: begin
                    write_reg(REG_ACC_SM, 32'h0);
                    write_reg(REG_ACC_LG, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(REG_ACC_SM, 32'hFFFF_FFFF);
                    write_reg(REG_ACC_LG, 32'h0);
                end
            endcase
            cfg_valid <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)      cmd = CMD_FLIP;
                else if (pick < 75) cmd = CMD_WRITE;
                else if (pick < 93) cmd = CMD_READ;
                else                cmd = CMD_SPARE;
                // Mostly sites inside the side in use, some beyond it.
                span = side_span();
                if (span < SIDE_DEFAULT && $urandom_range(0, 9) == 0)
                    x = $urandom_range(span, SIDE_DEFAULT - 1);
                else
                    x = $urandom_range(0, span - 1);
                if (span < SIDE_DEFAULT && $urandom_range(0, 9) == 0)
                    y = $urandom_range(span, SIDE_DEFAULT - 1);
                else
                    y = $urandom_range(0, span - 1);
                // A quarter of the fractions land right around a threshold.
                if ($urandom_range(0, 3) == 0)
                    frac = ($urandom_range(0, 1) ? thr_small : thr_large)
                         + $urandom_range(0, 2) - 1;
                else
                    frac = $urandom;
                send_site(cmd, x, y, frac, $urandom_range(0, 1), 1'b0, NONE_KNOWN);
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
